FILE: src/bge_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// bge_pkg
// Types and constants shared by the bump-map gradient engine modules.
// ============================================================================
package bge_pkg;

    // Request kinds carried in tuser.
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_READ  = 1'b1;

    // Gradient bias added to both bump bytes.
    localparam logic [7:0] MID_LEVEL = 8'd128;

    // Division by three of a sum below 1024: floor(sum * 683 / 2048).
    localparam int unsigned SUM_W      = 10;
    localparam logic [SUM_W-1:0] DIV3_MUL = 10'd683;
    localparam int unsigned DIV3_SHIFT = 11;
    localparam int unsigned PROD_W     = 2 * SUM_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_RD_RIGHT,
        ST_RD_LEFT,
        ST_RD_DOWN,
        ST_RD_UP,
        ST_ACC_UP,
        ST_LIGHT
    } state_t;

    typedef enum logic [2:0] {
        ASEL_SELF,
        ASEL_RIGHT,
        ASEL_LEFT,
        ASEL_DOWN,
        ASEL_UP
    } addr_sel_t;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD_X,
        OP_SUB_X,
        OP_ADD_Y,
        OP_SUB_Y,
        OP_LIGHT
    } alu_op_t;

    typedef struct packed {
        logic      s_ready;
        logic      store_we;
        addr_sel_t addr_sel;
        alu_op_t   alu_op;
        logic      out_load;
    } ctrl_t;

endpackage

FILE: src/bge_store.sv
`timescale 1ns / 1ps
// ============================================================================
// bge_store
// Single-port intensity store with one write or one registered read a cycle.
// ============================================================================
module bge_store #(
    parameter int unsigned ADDR_W = 16
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] addr,
    input  logic [7:0]        wr_data,
    output logic [7:0]        rd_data
);

    localparam int unsigned DEPTH = 1 << ADDR_W;

    logic [7:0] mem [0:DEPTH-1];
    logic [7:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[addr] <= wr_data;
        end
        rd_data_reg <= mem[addr];
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: src/bumpmap_gradient_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// bumpmap_gradient_engine
// Emboss bump-map engine: stores pixel intensities and forms gradients.
// ============================================================================
// Usage:
// The slave stream carries one request item per handshake. tuser selects the
// kind: a write stores (red+green+blue)/3 at pixel_index, a read returns the
// two central-difference bump bytes and the lightmap address on the master
// stream. Writes produce no output item.
// Sequencing: every item is handled by a small sequencer around one shared
// add/subtract unit and a single-port store. A write is accepted, then
// written to the store. A read makes four neighbor reads from the single
// store port, each followed in the next state by an accumulate in the
// shared unit, then the lightmap add, whose result is loaded into the
// output register and shown on m_axis_tvalid.
// s_axis_tready is high only while the sequencer is idle. The result sits in
// an output register, so a new item is accepted while a result waits; if the
// receiver stalls, the next read waits in its final step until the output
// register frees up.
// Reset clears the sequencer, the output valid flag and light_offset. The
// store is not cleared: a read of a never-written neighbor returns an
// arbitrary value. light_offset is written through cfg_wr_en/cfg_wr_data;
// the user must do so only while the engine is idle; it is not enforced.
// ============================================================================
module bumpmap_gradient_engine #(
    parameter int unsigned SIDE_LOG2 = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration: light_offset.
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    // Request stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: pixel_index[15:0], red[23:16], green[31:24], blue[39:32]
    input  logic [39:0] s_axis_tdata,
    // tuser: req_type[0]
    input  logic        s_axis_tuser,
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: bump_x[7:0], bump_y[15:8], light_index[31:16]
    output logic [31:0] m_axis_tdata
);

    import bge_pkg::*;

    localparam int unsigned ADDR_W = 2 * SIDE_LOG2;
    localparam logic [ADDR_W-1:0] ONE_STEP  = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] SIDE_STEP = ADDR_W'(1) << SIDE_LOG2;

    // Input field unpacking.
    logic [15:0] in_pixel_index;
    logic [7:0]  in_red;
    logic [7:0]  in_green;
    logic [7:0]  in_blue;

    assign in_pixel_index = s_axis_tdata[15:0];
    assign in_red         = s_axis_tdata[23:16];
    assign in_green       = s_axis_tdata[31:24];
    assign in_blue        = s_axis_tdata[39:32];

    state_t state_reg;
    state_t state_next;
    ctrl_t  ctrl;

    logic [ADDR_W-1:0] idx_reg;
    logic [7:0]        red_reg;
    logic [7:0]        green_reg;
    logic [7:0]        blue_reg;
    logic              kind_reg;
    logic [7:0]        acc_x_reg;
    logic [7:0]        acc_y_reg;
    logic [7:0]        light_offset_reg;

    logic              m_valid_reg;
    logic [7:0]        bump_x_reg;
    logic [7:0]        bump_y_reg;
    logic [15:0]       light_index_reg;

    logic              s_accept;
    logic [ADDR_W-1:0] in_idx;
    logic [7:0]        in_col;
    logic [7:0]        in_row;

    assign s_accept = s_axis_tvalid && ctrl.s_ready;
    assign in_idx   = ADDR_W'(in_pixel_index);
    assign in_col   = 8'(in_idx[SIDE_LOG2-1:0]);
    assign in_row   = 8'(in_idx[ADDR_W-1:SIDE_LOG2]);

    // ------------------------------------------------------------------
    // Sequencer: next state.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = (s_axis_tuser == REQ_READ) ? ST_RD_RIGHT : ST_WRITE;
                end
            end
            ST_WRITE:    state_next = ST_IDLE;
            ST_RD_RIGHT: state_next = ST_RD_LEFT;
            ST_RD_LEFT:  state_next = ST_RD_DOWN;
            ST_RD_DOWN:  state_next = ST_RD_UP;
            ST_RD_UP:    state_next = ST_ACC_UP;
            ST_ACC_UP:   state_next = ST_LIGHT;
            ST_LIGHT:
            begin
                if (ctrl.out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer: control outputs. Store reads are issued one state ahead
    // of the accumulate that consumes the registered read data.
    // ------------------------------------------------------------------
    always_comb
    begin
        ctrl.s_ready  = 1'b0;
        ctrl.store_we = 1'b0;
        ctrl.addr_sel = ASEL_SELF;
        ctrl.alu_op   = OP_NONE;
        ctrl.out_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:     ctrl.s_ready = 1'b1;
            ST_WRITE:    ctrl.store_we = 1'b1;
            ST_RD_RIGHT: ctrl.addr_sel = ASEL_RIGHT;
            ST_RD_LEFT:
            begin
                ctrl.addr_sel = ASEL_LEFT;
                ctrl.alu_op   = OP_ADD_X;
            end
            ST_RD_DOWN:
            begin
                ctrl.addr_sel = ASEL_DOWN;
                ctrl.alu_op   = OP_SUB_X;
            end
            ST_RD_UP:
            begin
                ctrl.addr_sel = ASEL_UP;
                ctrl.alu_op   = OP_ADD_Y;
            end
            ST_ACC_UP:   ctrl.alu_op = OP_SUB_Y;
            ST_LIGHT:
            begin
                ctrl.alu_op   = OP_LIGHT;
                ctrl.out_load = !m_valid_reg || m_axis_tready;
            end
            default:     ctrl.s_ready = 1'b0;
        endcase
    end

    // ------------------------------------------------------------------
    // Store address and write data.
    // ------------------------------------------------------------------
    logic [ADDR_W-1:0] store_addr;
    logic [7:0]        store_rd_data;
    logic [SUM_W-1:0]  rgb_sum;
    logic [PROD_W-1:0] div3_prod;
    logic [7:0]        intensity;

    always_comb
    begin
        case (ctrl.addr_sel)
            ASEL_RIGHT: store_addr = idx_reg + ONE_STEP;
            ASEL_LEFT:  store_addr = idx_reg - ONE_STEP;
            ASEL_DOWN:  store_addr = idx_reg + SIDE_STEP;
            ASEL_UP:    store_addr = idx_reg - SIDE_STEP;
            default:    store_addr = idx_reg;
        endcase
    end

    // Average of the three channels by reciprocal multiplication.
    assign rgb_sum   = SUM_W'(red_reg) + SUM_W'(green_reg) + SUM_W'(blue_reg);
    assign div3_prod = PROD_W'(rgb_sum) * PROD_W'(DIV3_MUL);
    assign intensity = div3_prod[DIV3_SHIFT +: 8];

    bge_store #(
        .ADDR_W (ADDR_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (ctrl.store_we),
        .addr    (store_addr),
        .wr_data (intensity),
        .rd_data (store_rd_data)
    );

    // ------------------------------------------------------------------
    // Shared add/subtract unit. Bump bytes use the low 8 bits; the final
    // step adds light_offset to the 16-bit bump word.
    // ------------------------------------------------------------------
    logic [15:0] alu_a;
    logic [15:0] alu_b;
    logic        alu_sub;
    logic [15:0] alu_result;

    always_comb
    begin
        alu_a   = {8'd0, acc_x_reg};
        alu_b   = {8'd0, store_rd_data};
        alu_sub = 1'b0;
        case (ctrl.alu_op)
            OP_SUB_X: alu_sub = 1'b1;
            OP_ADD_Y: alu_a = {8'd0, acc_y_reg};
            OP_SUB_Y:
            begin
                alu_a   = {8'd0, acc_y_reg};
                alu_sub = 1'b1;
            end
            OP_LIGHT:
            begin
                alu_a = {acc_y_reg, acc_x_reg};
                alu_b = {8'd0, light_offset_reg};
            end
            default: alu_sub = 1'b0;
        endcase
        alu_result = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    // ------------------------------------------------------------------
    // Control registers.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            light_offset_reg <= 8'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_wr_en)
            begin
                light_offset_reg <= cfg_wr_data;
            end
            if (ctrl.out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Payload registers. The accumulators start at 128 minus column/row.
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            idx_reg   <= in_idx;
            red_reg   <= in_red;
            green_reg <= in_green;
            blue_reg  <= in_blue;
            kind_reg  <= s_axis_tuser;
            acc_x_reg <= MID_LEVEL - in_col;
            acc_y_reg <= MID_LEVEL - in_row;
        end
        else
        begin
            case (ctrl.alu_op)
                OP_ADD_X, OP_SUB_X: acc_x_reg <= alu_result[7:0];
                OP_ADD_Y, OP_SUB_Y: acc_y_reg <= alu_result[7:0];
                default:            acc_x_reg <= acc_x_reg;
            endcase
        end
        if (ctrl.out_load && (kind_reg == REQ_READ))
        begin
            bump_x_reg      <= acc_x_reg;
            bump_y_reg      <= acc_y_reg;
            light_index_reg <= alu_result;
        end
    end

    assign s_axis_tready = ctrl.s_ready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {light_index_reg, bump_y_reg, bump_x_reg};

endmodule

FILE: tb/tb_bumpmap_gradient_engine.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_bumpmap_gradient_engine
// Self-checking regression for the emboss bump-map gradient engine.
// ============================================================================
// The bench streams intensity writes and bump reads into the engine. It keeps
// its own mirror of the intensity store and of light_offset, and it predicts
// bump_x, bump_y and light_index for every read at the moment the read is
// accepted. A checker process pops the oldest prediction for every result
// item and compares it field by field. Reads are only issued at pixels whose
// four neighbors have been written, because the store holds garbage until a
// pixel is first written. The sender runs in bursts with random gaps. The
// receiver stalls in modes of its own. light_offset is only changed once
// the engine has gone quiet.
// ============================================================================
module tb_bumpmap_gradient_engine;

    import bge_pkg::*;

    // One predicted or observed result item, packed in tdata order.
    typedef struct packed {
        logic [15:0] light_index;
        logic [7:0]  bump_y;
        logic [7:0]  bump_x;
    } bump_result_t;

    // Items per random phase; four phases plus the directed part make about 2000.
    localparam int unsigned PHASE_ITEMS = 495;
    // Quiet cycles after the last result, so that a trailing write can retire.
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned DRAIN_LIMIT = 100000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [7:0]  cfg_wr_data = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // tdata: pixel_index[15:0], red[23:16], green[31:24], blue[39:32]
    logic [39:0] s_axis_tdata = 40'd0;
    // tuser: req_type[0]
    logic        s_axis_tuser = REQ_WRITE;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // tdata: bump_x[7:0], bump_y[15:8], light_index[31:16]
    logic [31:0] m_axis_tdata;

    // Mirror of the engine state.
    logic [7:0]   level_mirror [0:65535];
    bit           cell_written [0:65535];
    logic [7:0]   light_offset_mirror = 8'd0;

    bump_result_t bump_expect_q[$];
    int unsigned  readable_pixels[$];
    int unsigned  error_count = 0;
    int unsigned  items_sent = 0;
    int unsigned  burst_left = 0;

    // Receiver stall pattern state.
    int unsigned  rx_mode = 0;
    int unsigned  rx_mode_left = 0;

    bumpmap_gradient_engine uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Central differences around one pixel. All index arithmetic is done at
    // 16 bits so that neighbors wrap round the whole store, and the bump
    // bytes are formed at 8 bits so that they wrap as the engine does.
    function automatic bump_result_t predict_bump(input logic [15:0] pix);
        bump_result_t res;
        logic [7:0]   column;
        logic [7:0]   row;
        logic [15:0]  right_idx;
        logic [15:0]  left_idx;
        logic [15:0]  down_idx;
        logic [15:0]  up_idx;
        column    = pix[7:0];
        row       = pix[15:8];
        right_idx = pix + 16'd1;
        left_idx  = pix - 16'd1;
        down_idx  = pix + 16'd256;
        up_idx    = pix - 16'd256;
        res.bump_x = level_mirror[right_idx] - level_mirror[left_idx] + MID_LEVEL - column;
        res.bump_y = level_mirror[down_idx] - level_mirror[up_idx] + MID_LEVEL - row;
        res.light_index = {res.bump_y, res.bump_x} + {8'd0, light_offset_mirror};
        return res;
    endfunction

    function automatic bit readable(input logic [15:0] pix);
        logic [15:0] right_idx;
        logic [15:0] left_idx;
        logic [15:0] down_idx;
        logic [15:0] up_idx;
        right_idx = pix + 16'd1;
        left_idx  = pix - 16'd1;
        down_idx  = pix + 16'd256;
        up_idx    = pix - 16'd256;
        return cell_written[right_idx] && cell_written[left_idx]
            && cell_written[down_idx] && cell_written[up_idx];
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("%0t: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got,
                 want);
        error_count++;
    endtask

    // Every result item is compared against the oldest prediction. A new
    // read may be pushed in the same time step as an older result is popped;
    // the older prediction is already in the queue then, so the order of the
    // two does not matter.
    always @(posedge clk)
    begin
        bump_result_t got;
        bump_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata;
            if (bump_expect_q.size() == 0)
            begin
                report_mismatch("result with no read pending", 32'(got), 0);
            end
            else
            begin
                want = bump_expect_q.pop_front();
                if (got.bump_x !== want.bump_x)
                    report_mismatch("bump_x", 32'(got.bump_x), 32'(want.bump_x));
                if (got.bump_y !== want.bump_y)
                    report_mismatch("bump_y", 32'(got.bump_y), 32'(want.bump_y));
                if (got.light_index !== want.light_index)
                    report_mismatch("light_index", 32'(got.light_index),
                                    32'(want.light_index));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stalls in modes that each last a random stretch of cycles.
    // Mode 0 and 1 never stall, mode 2 stalls half the time, mode 3 mostly.
    // ------------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rx_mode_left == 0)
        begin
            rx_mode      = $urandom_range(0, 3);
            rx_mode_left = $urandom_range(16, 96);
        end
        else
        begin
            rx_mode_left--;
        end
        case (rx_mode)
            2:       m_axis_tready <= ($urandom_range(0, 1) == 1);
            3:       m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: m_axis_tready <= 1'b1;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sender
    // ------------------------------------------------------------------------

    // Offers one item, waits for the handshake and updates the mirror. tvalid
    // stays high afterwards unless the burst has run out, so back-to-back
    // items never see a low-high glitch within one step.
    task automatic send_item(input logic kind, input logic [15:0] pix,
                             input logic [7:0] red, input logic [7:0] green,
                             input logic [7:0] blue);
        int unsigned sum;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {blue, green, red, pix};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (kind == REQ_WRITE)
        begin
            sum = red + green + blue;
            level_mirror[pix] = 8'(sum / 3);
            cell_written[pix] = 1'b1;
        end
        else
        begin
            bump_expect_q.push_back(predict_bump(pix));
        end
        items_sent++;
        // Burst pacing: most bursts are short, some run long with no gaps.
        if (burst_left > 0)
        begin
            burst_left--;
        end
        else
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 200 : $urandom_range(0, 15);
        end
    endtask

    task automatic write_pixel(input logic [15:0] pix, input logic [7:0] red,
                               input logic [7:0] green, input logic [7:0] blue);
        send_item(REQ_WRITE, pix, red, green, blue);
    endtask

    // Unused color fields of a read carry random bits; the engine ignores them.
    task automatic read_pixel(input logic [15:0] pix);
        send_item(REQ_READ, pix, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)));
    endtask

    // Holds the sender until every predicted result is back, then lets a few
    // more cycles pass so that a trailing write has left the sequencer.
    task automatic wait_for_drain;
        int unsigned guard;
        guard = 0;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (bump_expect_q.size() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Must only be called with the engine idle.
    task automatic set_light_offset(input logic [7:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        light_offset_mirror = value;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [7:0] rand_channel;
        case ($urandom_range(0, 7))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Random pixel index, biased towards the store's edges where the
    // neighbors wrap into the next row or round the whole frame.
    function automatic logic [15:0] edge_index;
        logic [15:0] pix;
        pix = 16'($urandom_range(0, 65535));
        case ($urandom_range(0, 7))
            0: pix[7:0]  = 8'd0;
            1: pix[7:0]  = 8'd255;
            2: pix[15:8] = 8'd0;
            3: pix[15:8] = 8'd255;
            default: ;
        endcase
        return pix;
    endfunction

    // Well-formed sequence: write the four neighbors (always where they are
    // still unwritten, otherwise most of the time), sometimes the pixel
    // itself, then read it.
    task automatic surround_and_read(input logic [15:0] pix);
        logic [15:0] nbr [4];
        nbr[0] = pix + 16'd1;
        nbr[1] = pix - 16'd1;
        nbr[2] = pix + 16'd256;
        nbr[3] = pix - 16'd256;
        foreach (nbr[k])
        begin
            if (!cell_written[nbr[k]] || $urandom_range(0, 3) != 0)
                write_pixel(nbr[k], rand_channel(), rand_channel(), rand_channel());
        end
        if ($urandom_range(0, 3) == 0)
            write_pixel(pix, rand_channel(), rand_channel(), rand_channel());
        read_pixel(pix);
        readable_pixels.push_back(32'(pix));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Corners and edges of the frame with extreme and uneven color sums, and
    // an overwrite followed by a second read. light_offset is still at its
    // reset value here.
    task automatic test_frame_edges;
        write_pixel(16'd1,     8'd255, 8'd255, 8'd255);
        write_pixel(16'd65535, 8'd0,   8'd0,   8'd0);
        write_pixel(16'd256,   8'd255, 8'd0,   8'd0);
        write_pixel(16'd65280, 8'd0,   8'd255, 8'd0);
        read_pixel(16'd0);
        write_pixel(16'd0,     8'd0,   8'd0,   8'd255);
        write_pixel(16'd65534, 8'd254, 8'd255, 8'd255);
        write_pixel(16'd255,   8'd2,   8'd2,   8'd1);
        write_pixel(16'd65279, 8'd128, 8'd127, 8'd128);
        read_pixel(16'd65535);
        write_pixel(16'd254,   8'd10,  8'd20,  8'd30);
        write_pixel(16'd511,   8'd200, 8'd100, 8'd50);
        read_pixel(16'd255);
        write_pixel(16'd65281, 8'd1,   8'd0,   8'd0);
        write_pixel(16'd65024, 8'd0,   8'd0,   8'd2);
        read_pixel(16'd65280);
        write_pixel(16'd1,     8'd1,   8'd1,   8'd1);
        read_pixel(16'd0);
        readable_pixels = '{0, 65535, 255, 65280};
    endtask

    // The largest and a middle light offset, so that light_index wraps.
    task automatic test_light_offset_extremes;
        logic [7:0] offsets [2];
        offsets = '{8'd255, 8'd128};
        foreach (offsets[k])
        begin
            wait_for_drain();
            set_light_offset(offsets[k]);
            foreach (readable_pixels[n])
                read_pixel(16'(readable_pixels[n]));
            surround_and_read(edge_index());
        end
    endtask

    // Mostly well-formed write-then-read sequences with random content, plus
    // reads of pixels already known to be safe, stray writes and sequences
    // abandoned before their read. Each phase runs with its own offset.
    task automatic test_random_traffic;
        logic [7:0]  offsets [4];
        logic [15:0] pix;
        int unsigned phase_end;
        int unsigned pick;
        offsets = '{8'd0, 8'd1, 8'($urandom_range(2, 254)), 8'($urandom_range(0, 255))};
        foreach (offsets[p])
        begin
            wait_for_drain();
            set_light_offset(offsets[p]);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 55)
                begin
                    surround_and_read(edge_index());
                end
                else if (pick < 75)
                begin
                    pix = 16'($urandom_range(0, 65535));
                    if (!readable(pix))
                        pix = 16'(readable_pixels[$urandom_range(0,
                                  readable_pixels.size() - 1)]);
                    read_pixel(pix);
                end
                else if (pick < 92)
                begin
                    write_pixel(edge_index(), rand_channel(), rand_channel(),
                                rand_channel());
                end
                else
                begin
                    // Broken sequence: neighbors written, read never issued.
                    pix = edge_index();
                    write_pixel(pix + 16'd1, rand_channel(), rand_channel(), rand_channel());
                    write_pixel(pix - 16'd256, rand_channel(), rand_channel(),
                                rand_channel());
                end
                // Occasionally hold the sender until the engine has caught up.
                if ($urandom_range(0, 199) == 0)
                    wait_for_drain();
            end
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_frame_edges();
        test_light_offset_extremes();
        test_random_traffic();

        wait_for_drain();
        while (bump_expect_q.size() != 0)
        begin
            void'(bump_expect_q.pop_front());
            report_mismatch("result never delivered", 0, 1);
        end

        if (error_count == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #10_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

FILE: filelist.f
src/bge_pkg.sv
src/bge_store.sv
src/bumpmap_gradient_engine.sv
tb/tb_bumpmap_gradient_engine.sv
